@@ sv/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assertion macros
// clocked property checks, compiled out for synthesis
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// check with synchronous reset masking
`define MET_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// check that also holds across reset
`define MET_ASSERT_NR(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define MET_ASSERT(lbl, clk, rst, prop, msg)
`define MET_ASSERT_NR(lbl, clk, prop, msg)
`endif
`endif

@@ sv/met_pkg.sv @@
// ----------------------------------------------------------------------------
// met_pkg
// shared types, constants and helpers of the escape-time pixel core
// ----------------------------------------------------------------------------
package met_pkg;

  localparam int MAX_DIM    = 4096;
  localparam int COUNT_BITS = 16;
  localparam int ACC_W      = 130;
  localparam int IDX_W      = 3;
  localparam int DIM_W      = 13;
  localparam int PIX_W      = 12;

  // configuration register indexes
  localparam logic [IDX_W-1:0] REG_CENTER_REAL     = 3'd0;
  localparam logic [IDX_W-1:0] REG_CENTER_IMAG     = 3'd1;
  localparam logic [IDX_W-1:0] REG_PIXEL_PITCH     = 3'd2;
  localparam logic [IDX_W-1:0] REG_CANVAS_WIDTH    = 3'd3;
  localparam logic [IDX_W-1:0] REG_CANVAS_HEIGHT   = 3'd4;
  localparam logic [IDX_W-1:0] REG_ITERATION_LIMIT = 3'd5;

  // 1e-12 in Q.80 units
  localparam logic [40:0] TINY_Q80 = 41'd1208925819615;

  typedef struct packed {
    logic signed [63:0]      center_real;
    logic signed [63:0]      center_imag;
    logic [62:0]             pixel_pitch;
    logic [DIM_W-1:0]        canvas_width;
    logic [DIM_W-1:0]        canvas_height;
    logic [COUNT_BITS-1:0]   iteration_limit;
  } cfg_t;

  typedef struct packed {
    logic                    issue;
    logic                    clear;
    logic                    sub;
    logic [1:0]              part;
    logic signed [63:0]      a;
    logic signed [63:0]      b;
    logic signed [ACC_W-1:0] init;
  } mac_cmd_t;

  // saturate a wide signed value to the signed 64-bit range
  function automatic logic signed [63:0] sat64(input logic signed [ACC_W-1:0] v);
    if (v[ACC_W-1:63] == '0 || v[ACC_W-1:63] == '1) begin
      return v[63:0];
    end else if (v[ACC_W-1]) begin
      return {1'b1, 63'b0};
    end else begin
      return {1'b0, {63{1'b1}}};
    end
  endfunction

endpackage

@@ sv/met_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// met_cfg_regs
// configuration register file, written through a plain write port
// ----------------------------------------------------------------------------
module met_cfg_regs import met_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [IDX_W-1:0] cfg_addr,
  input  logic [63:0]      cfg_wdata,
  output cfg_t             cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.center_real     <= '0;
      cfg.center_imag     <= '0;
      cfg.pixel_pitch     <= 63'd576460752303423;
      cfg.canvas_width    <= 13'd640;
      cfg.canvas_height   <= 13'd480;
      cfg.iteration_limit <= 16'd256;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_CENTER_REAL:     cfg.center_real     <= cfg_wdata;
        REG_CENTER_IMAG:     cfg.center_imag     <= cfg_wdata;
        REG_PIXEL_PITCH:     cfg.pixel_pitch     <= cfg_wdata[62:0];
        REG_CANVAS_WIDTH:    cfg.canvas_width    <= cfg_wdata[DIM_W-1:0];
        REG_CANVAS_HEIGHT:   cfg.canvas_height   <= cfg_wdata[DIM_W-1:0];
        REG_ITERATION_LIMIT: cfg.iteration_limit <= cfg_wdata[COUNT_BITS-1:0];
        default: ;
      endcase
    end
  end

endmodule

@@ sv/met_mac.sv @@
// ----------------------------------------------------------------------------
// met_mac
// shared 32x32 multiply-accumulate unit, one partial product per cycle
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module met_mac import met_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  mac_cmd_t                cmd,
  output logic                    idle,
  output logic signed [ACC_W-1:0] acc
);

  logic [63:0]      mag_a, mag_b;
  logic [31:0]      half_a, half_b;
  logic             s1_valid, s1_neg;
  logic [1:0]       s1_sh;
  logic [31:0]      s1_a, s1_b;
  logic             s2_valid, s2_neg;
  logic [1:0]       s2_sh;
  logic [63:0]      s2_prod;
  logic [ACC_W-1:0] prod_ext, term;

  // operand magnitudes and the selected 32-bit halves
  always_comb begin
    mag_a  = cmd.a[63] ? (~cmd.a + 64'd1) : cmd.a;
    mag_b  = cmd.b[63] ? (~cmd.b + 64'd1) : cmd.b;
    half_a = cmd.part[1] ? mag_a[63:32] : mag_a[31:0];
    half_b = cmd.part[0] ? mag_b[63:32] : mag_b[31:0];
  end

  always_comb begin
    prod_ext = {{(ACC_W-64){1'b0}}, s2_prod};
    case (s2_sh)
      2'd0:    term = prod_ext;
      2'd1:    term = prod_ext << 32;
      default: term = prod_ext << 64;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      s1_valid <= cmd.issue;
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    s1_a    <= half_a;
    s1_b    <= half_b;
    s1_neg  <= cmd.a[63] ^ cmd.b[63] ^ cmd.sub;
    s1_sh   <= {1'b0, cmd.part[1]} + {1'b0, cmd.part[0]};
    s2_prod <= {32'b0, s1_a} * {32'b0, s1_b};
    s2_neg  <= s1_neg;
    s2_sh   <= s1_sh;
    if (cmd.clear) begin
      acc <= cmd.init;
    end else if (s2_valid) begin
      acc <= s2_neg ? (acc - $signed(term)) : (acc + $signed(term));
    end
  end

  assign idle = !s1_valid && !s2_valid;

  `MET_ASSERT(a_clear_empty, clk, rst, cmd.clear |-> (!s1_valid && !s2_valid), "acc cleared with products in flight")
  `MET_ASSERT(a_shift_range, clk, rst, s1_valid |-> (s1_sh != 2'd3), "partial product shift out of range")
  `MET_ASSERT(a_pipe_follow, clk, rst, s2_valid |-> $past(cmd.issue, 2), "product without an issue")

endmodule

@@ sv/mandelbrot_escape_time_pixel_core.sv @@
// ----------------------------------------------------------------------------
// mandelbrot_escape_time_pixel_core
// escape-time pixel engine with a derivative interior check
// ----------------------------------------------------------------------------
// Usage: raise start with pixel_x/pixel_y while busy is low; the transaction
// is taken at that edge and busy rises. When the pixel is finished, done is
// high for exactly one cycle with escape_count (0 for interior or limit).
// The receiver cannot stall; busy falls in the cycle done is shown, so the
// next pixel can be started in that cycle.
// Configuration is written over cfg_we/cfg_addr/cfg_wdata, one register per
// cycle, while no pixel is in flight.
// The pixel is mapped first, then iterated; iterations where the derivative is
// small enough to be tested run an extra test product.
// One pixel at a time: every 64-bit product runs as four 32x32 partial
// products through the single shared multiply-accumulate unit, and each
// product group waits out its three-stage pipeline before the result is
// stored.
// Reset restores the register defaults and returns to idle with done low.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mandelbrot_escape_time_pixel_core import met_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  logic [PIX_W-1:0]      pixel_x,
  input  logic [PIX_W-1:0]      pixel_y,
  output logic                  done,
  output logic [COUNT_BITS-1:0] escape_count,
  input  logic                  cfg_we,
  input  logic [IDX_W-1:0]      cfg_addr,
  input  logic [63:0]           cfg_wdata
);

  typedef enum logic [2:0] {ST_IDLE, ST_MUL, ST_DRAIN, ST_ZADD, ST_RSUM, ST_ESC} state_t;
  typedef enum logic [2:0] {J_CRE, J_CIM, J_TINY, J_DRE, J_DIM, J_ZR, J_ZI, J_W} job_t;

  localparam logic signed [63:0] DR_ONE    = 64'sh0000_0100_0000_0000;
  localparam logic [64:0]        FOUR_Q59  = 65'h1 << 61;

  cfg_t                    cfg;
  mac_cmd_t                cmd;
  logic                    mac_idle;
  logic signed [ACC_W-1:0] acc, acc_shift;
  state_t                  state;
  job_t                    job;
  logic [2:0]              cnt, cnt_last;
  logic signed [13:0]      twice_x, twice_y, twice_x_next, twice_y_next;
  logic [DIM_W-1:0]        w_size, h_size;
  logic signed [63:0]      cr, ci, zr, zi, w, re, im, s, dr, di, ndr;
  logic signed [63:0]      re_next, im_next, s_next, store_val;
  logic signed [65:0]      re_sum, im_sum;
  logic signed [64:0]      rs_sum;
  logic [64:0]             esc_sum;
  logic [COUNT_BITS-1:0]   l;
  logic [COUNT_BITS:0]     l_inc;
  logic                    small_d, tiny_hit, escaped, limit_ok;

  function automatic logic small21(input logic signed [63:0] v);
    return (v[63:21] == '0) || (v[63:21] == '1 && v[20:0] != '0);
  endfunction

  met_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  met_mac u_mac (
    .clk  (clk),
    .rst  (rst),
    .cmd  (cmd),
    .idle (mac_idle),
    .acc  (acc)
  );

  // pixel to doubled offset from the canvas center
  always_comb begin
    w_size = (32'(cfg.canvas_width) > MAX_DIM) ? DIM_W'(MAX_DIM) : cfg.canvas_width;
    h_size = (32'(cfg.canvas_height) > MAX_DIM) ? DIM_W'(MAX_DIM) : cfg.canvas_height;
    twice_x_next = $signed({1'b0, pixel_x, 1'b0}) - $signed({1'b0, w_size});
    twice_y_next = $signed({1'b0, pixel_y, 1'b0}) - $signed({1'b0, h_size});
  end

  always_comb begin
    re_sum   = 66'(zr) - 66'(zi) + 66'(cr);
    im_sum   = 66'(w) - 66'(zr) - 66'(zi) + 66'(ci);
    re_next  = sat64(ACC_W'(re_sum));
    im_next  = sat64(ACC_W'(im_sum));
    rs_sum   = 65'(re) + 65'(im);
    s_next   = sat64(ACC_W'(rs_sum));
    small_d  = small21(dr) && small21(di);
    tiny_hit = $unsigned(acc) < ACC_W'(TINY_Q80);
    esc_sum  = {1'b0, zr} + {1'b0, zi};
    escaped  = esc_sum > FOUR_Q59;
    l_inc    = {1'b0, l} + 1'b1;
    limit_ok = l_inc < {1'b0, cfg.iteration_limit};
  end

  always_comb begin
    case (job) inside
      J_CRE, J_CIM: acc_shift = acc >>> 1;
      J_DRE, J_DIM: acc_shift = acc >>> 58;
      default:      acc_shift = acc >>> 59;
    endcase
    store_val = sat64(acc_shift);
  end

  // operand selection for the shared unit: cnt[2] picks the term, cnt[1:0] the part
  always_comb begin
    cmd.issue = (state == ST_MUL);
    cmd.clear = (state == ST_MUL) && (cnt == 3'd0);
    cmd.part  = cnt[1:0];
    cmd.sub   = (job == J_DRE) && cnt[2];
    cmd.init  = '0;
    cnt_last  = 3'd3;
    unique case (job)
      J_CRE: begin
        cmd.a    = 64'(twice_x);
        cmd.b    = {1'b0, cfg.pixel_pitch};
        cmd.init = ACC_W'(cfg.center_real) <<< 1;
      end
      J_CIM: begin
        cmd.a    = 64'(twice_y);
        cmd.b    = {1'b0, cfg.pixel_pitch};
        cmd.init = ACC_W'(cfg.center_imag) <<< 1;
      end
      J_TINY: begin
        cmd.a    = cnt[2] ? di : dr;
        cmd.b    = cnt[2] ? di : dr;
        cnt_last = 3'd7;
      end
      J_DRE: begin
        cmd.a    = cnt[2] ? di : dr;
        cmd.b    = cnt[2] ? im : re;
        cnt_last = 3'd7;
      end
      J_DIM: begin
        cmd.a    = cnt[2] ? di : dr;
        cmd.b    = cnt[2] ? re : im;
        cnt_last = 3'd7;
      end
      J_ZR: begin
        cmd.a = re;
        cmd.b = re;
      end
      J_ZI: begin
        cmd.a = im;
        cmd.b = im;
      end
      J_W: begin
        cmd.a = s;
        cmd.b = s;
      end
    endcase
  end

  assign busy = (state != ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      done  <= 1'b0;
      cnt   <= '0;
      job   <= J_CRE;
    end else begin
      done <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (start) begin
            twice_x <= twice_x_next;
            twice_y <= twice_y_next;
            job     <= J_CRE;
            cnt     <= '0;
            state   <= ST_MUL;
          end
        end
        ST_MUL: begin
          if (cnt == cnt_last) begin
            cnt   <= '0;
            state <= ST_DRAIN;
          end else begin
            cnt <= cnt + 3'd1;
          end
        end
        ST_DRAIN: begin
          if (mac_idle) begin
            state <= ST_MUL;
            unique case (job)
              J_CRE: begin
                cr  <= store_val;
                job <= J_CIM;
              end
              J_CIM: begin
                ci <= store_val;
                zr <= '0;
                zi <= '0;
                w  <= '0;
                dr <= DR_ONE;
                di <= '0;
                l  <= COUNT_BITS'(1);
                if (cfg.iteration_limit <= COUNT_BITS'(1)) begin
                  done         <= 1'b1;
                  escape_count <= '0;
                  state        <= ST_IDLE;
                end else begin
                  state <= ST_ZADD;
                end
              end
              J_TINY: begin
                // derivative collapsed: point is interior
                if (tiny_hit) begin
                  done         <= 1'b1;
                  escape_count <= '0;
                  state        <= ST_IDLE;
                end else begin
                  job <= J_DRE;
                end
              end
              J_DRE: begin
                ndr <= store_val;
                job <= J_DIM;
              end
              J_DIM: begin
                dr  <= ndr;
                di  <= store_val;
                job <= J_ZR;
              end
              J_ZR: begin
                zr  <= store_val;
                job <= J_ZI;
              end
              J_ZI: begin
                zi  <= store_val;
                job <= J_W;
              end
              J_W: begin
                w     <= store_val;
                state <= ST_ESC;
              end
            endcase
          end
        end
        ST_ZADD: begin
          re    <= re_next;
          im    <= im_next;
          state <= ST_RSUM;
        end
        ST_RSUM: begin
          s     <= s_next;
          job   <= small_d ? J_TINY : J_DRE;
          state <= ST_MUL;
        end
        ST_ESC: begin
          if (escaped) begin
            done         <= 1'b1;
            escape_count <= l;
            state        <= ST_IDLE;
          end else if (!limit_ok) begin
            done         <= 1'b1;
            escape_count <= '0;
            state        <= ST_IDLE;
          end else begin
            l     <= l_inc[COUNT_BITS-1:0];
            state <= ST_ZADD;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  `MET_ASSERT(a_done_idle, clk, rst, done |-> !busy, "result strobe while busy")
  `MET_ASSERT(a_accept_busy, clk, rst, (start && !busy) |=> busy, "accepted transaction not started")
  `MET_ASSERT(a_count_from_esc, clk, rst, (done && escape_count != '0) |-> ($past(state) == ST_ESC), "nonzero count not from escape test")
  `MET_ASSERT_NR(a_reset_quiet, clk, rst |=> (!done && !busy), "not idle after reset")

endmodule

@@ test/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the escape-time pixel core: every accepted pixel is
// run through a bit-accurate fixed-point predictor and the escape count the
// core returns is compared in order; directed corner cases come first, then
// randomized views and extreme register settings with random start gaps
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top;
  import met_pkg::*;

  localparam int    RANDOM_ITEMS = 1400;
  localparam int    QUIET_FROM   = 1250;
  localparam int    TAIL_CYCLES  = 64;

  localparam logic [IDX_W-1:0] REG_UNUSED_LO = 3'd6;
  localparam logic [IDX_W-1:0] REG_UNUSED_HI = 3'd7;

  // 0.001 and 2.0 in Q4.59
  localparam longint MILLI_Q59 = 64'sd576460752303423;
  localparam longint TWO_Q59   = 64'sh1000_0000_0000_0000;

  localparam logic signed [63:0] S64_TOP    = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] S64_BOTTOM = 64'sh8000_0000_0000_0000;
  localparam logic [62:0]        PITCH_TOP  = 63'h7FFF_FFFF_FFFF_FFFF;

  class escape_scoreboard;
    typedef logic signed [131:0] acc_t;
    typedef struct {
      logic [PIX_W-1:0]      px;
      logic [PIX_W-1:0]      py;
      logic [COUNT_BITS-1:0] count;
    } pixel_job_t;

    localparam acc_t WIDE_TOP    = 132'sh7FFF_FFFF_FFFF_FFFF;
    localparam acc_t WIDE_BOTTOM = -132'sh8000_0000_0000_0000;
    localparam acc_t ESCAPE_R2   = 132'sh2000_0000_0000_0000;
    // 1e-12 in Q.80
    localparam acc_t TINY_D2     = 132'sd1208925819615;
    localparam logic signed [63:0] D_ONE = 64'sh0000_0100_0000_0000;

    logic signed [63:0]    center_re;
    logic signed [63:0]    center_im;
    logic [62:0]           pitch;
    logic [DIM_W-1:0]      width;
    logic [DIM_W-1:0]      height;
    logic [COUNT_BITS-1:0] limit;

    pixel_job_t pending_q[$];
    int mismatches;
    int pixels_noted;
    int escaped;
    int stayed;

    function new();
      center_re = '0;
      center_im = '0;
      pitch = 63'd576460752303423;
      width = 13'd640;
      height = 13'd480;
      limit = 16'd256;
      mismatches = 0;
      pixels_noted = 0;
      escaped = 0;
      stayed = 0;
    endfunction

    function void write_reg(logic [IDX_W-1:0] idx, logic [63:0] data);
      case (idx)
        REG_CENTER_REAL:     center_re = data;
        REG_CENTER_IMAG:     center_im = data;
        REG_PIXEL_PITCH:     pitch = data[62:0];
        REG_CANVAS_WIDTH:    width = data[DIM_W-1:0];
        REG_CANVAS_HEIGHT:   height = data[DIM_W-1:0];
        REG_ITERATION_LIMIT: limit = data[COUNT_BITS-1:0];
        default: ;
      endcase
    endfunction

    // longest quiet stretch a correct core can show with the current limit
    function int stall_budget();
      return 4 * (64 + 57 * int'(limit)) + 256;
    endfunction

    function logic signed [63:0] saturate(acc_t v);
      if (v > WIDE_TOP) return S64_TOP;
      if (v < WIDE_BOTTOM) return S64_BOTTOM;
      return v[63:0];
    endfunction

    function logic signed [63:0] map_axis(logic signed [63:0] center,
                                          logic [PIX_W-1:0] pix, logic [DIM_W-1:0] size);
      logic [DIM_W-1:0] sz;
      acc_t twice;
      acc_t offset;
      sz = (size > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : size;
      twice = 2 * acc_t'(pix) - acc_t'(sz);
      offset = (twice * acc_t'(pitch)) >>> 1;
      return saturate(offset + acc_t'(center));
    endfunction

    function logic [COUNT_BITS-1:0] escape_count_of(logic [PIX_W-1:0] px,
                                                    logic [PIX_W-1:0] py);
      logic signed [63:0] cr, ci, zr, zi, w, re, im, sum, dr, di, ndr, ndi;
      int step;
      cr = map_axis(center_re, px, width);
      ci = map_axis(center_im, py, height);
      zr = '0;
      zi = '0;
      w = '0;
      dr = D_ONE;
      di = '0;
      for (step = 1; step < int'(limit); step++) begin
        re = saturate(acc_t'(zr) - acc_t'(zi) + acc_t'(cr));
        im = saturate(acc_t'(w) - acc_t'(zr) - acc_t'(zi) + acc_t'(ci));
        // derivative collapsed: point sits in an attracting cycle
        if (acc_t'(dr) * acc_t'(dr) + acc_t'(di) * acc_t'(di) < TINY_D2) return '0;
        ndr = saturate((acc_t'(dr) * acc_t'(re) - acc_t'(di) * acc_t'(im)) >>> 58);
        ndi = saturate((acc_t'(dr) * acc_t'(im) + acc_t'(di) * acc_t'(re)) >>> 58);
        dr = ndr;
        di = ndi;
        zr = saturate((acc_t'(re) * acc_t'(re)) >>> 59);
        zi = saturate((acc_t'(im) * acc_t'(im)) >>> 59);
        sum = saturate(acc_t'(re) + acc_t'(im));
        w = saturate((acc_t'(sum) * acc_t'(sum)) >>> 59);
        if (acc_t'(zr) + acc_t'(zi) > ESCAPE_R2) return step[COUNT_BITS-1:0];
      end
      return '0;
    endfunction

    function void report(string msg);
      $display("mismatch: %s", msg);
      mismatches++;
    endfunction

    function void note_pixel(logic [PIX_W-1:0] px, logic [PIX_W-1:0] py);
      pixel_job_t job;
      job.px = px;
      job.py = py;
      job.count = escape_count_of(px, py);
      if (job.count == 0) stayed++;
      else escaped++;
      pixels_noted++;
      pending_q.push_back(job);
    endfunction

    function void check_result(logic [COUNT_BITS-1:0] got);
      pixel_job_t job;
      if (pending_q.size() == 0) begin
        report($sformatf("escape_count %0d with no pixel in flight", got));
        return;
      end
      job = pending_q.pop_front();
      if (got !== job.count) begin
        report($sformatf("pixel (%0d,%0d) escape_count %0d, predicted %0d",
                         job.px, job.py, got, job.count));
      end
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  start = 1'b0;
  logic                  busy;
  logic [PIX_W-1:0]      pixel_x = '0;
  logic [PIX_W-1:0]      pixel_y = '0;
  logic                  done;
  logic [COUNT_BITS-1:0] escape_count;
  logic                  cfg_we = 1'b0;
  logic [IDX_W-1:0]      cfg_addr = '0;
  logic [63:0]           cfg_wdata = '0;

  escape_scoreboard sb = new();
  int idle_cycles = 0;
  int settings_used = 0;

  mandelbrot_escape_time_pixel_core dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .pixel_x      (pixel_x),
    .pixel_y      (pixel_y),
    .done         (done),
    .escape_count (escape_count),
    .cfg_we       (cfg_we),
    .cfg_addr     (cfg_addr),
    .cfg_wdata    (cfg_wdata)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin : bus_monitor
    bit moved;
    moved = 1'b0;
    if (!rst) begin
      if (cfg_we) begin
        sb.write_reg(cfg_addr, cfg_wdata);
        moved = 1'b1;
      end
      if (done) begin
        sb.check_result(escape_count);
        moved = 1'b1;
      end
      if (start && !busy) begin
        sb.note_pixel(pixel_x, pixel_y);
        moved = 1'b1;
      end
      if (moved) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= sb.stall_budget()) begin
        $display("watchdog: no transaction in %0d cycles, %0d pixels in flight",
                 idle_cycles, sb.pending_q.size());
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  // all driver tasks are entered and left just after a falling edge
  task automatic drain();
    start <= 1'b0;
    while (sb.pending_q.size() != 0 || busy) @(negedge clk);
  endtask

  task automatic write_port(input logic [IDX_W-1:0] idx, input logic [63:0] data);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= data;
    @(negedge clk);
  endtask

  // junk above the width of the pitch, canvas and limit registers must be dropped by the core
  task automatic load_registers(input logic signed [63:0] cr, input logic signed [63:0] ci,
                                input logic [62:0] pitch, input logic [DIM_W-1:0] w,
                                input logic [DIM_W-1:0] h, input logic [15:0] lim);
    logic [63:0] junk;
    drain();
    junk = {$urandom, $urandom};
    write_port(REG_CENTER_REAL, cr);
    write_port(REG_CENTER_IMAG, ci);
    write_port(REG_PIXEL_PITCH, {junk[63], pitch});
    write_port(REG_CANVAS_WIDTH, {junk[63:DIM_W], w});
    junk = {$urandom, $urandom};
    write_port(REG_CANVAS_HEIGHT, {junk[63:DIM_W], h});
    write_port(REG_ITERATION_LIMIT, {junk[63:16], lim});
    if ($urandom_range(0, 2) == 0) begin
      write_port($urandom_range(0, 1) ? REG_UNUSED_HI : REG_UNUSED_LO, {$urandom, $urandom});
    end
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  task automatic send_pixel(input logic [PIX_W-1:0] x, input logic [PIX_W-1:0] y,
                            input bit gaps);
    if (gaps && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      pixel_x <= PIX_W'($urandom);
      pixel_y <= PIX_W'($urandom);
      repeat ($urandom_range(1, 5)) @(negedge clk);
    end
    start <= 1'b1;
    pixel_x <= x;
    pixel_y <= y;
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
    @(negedge clk);
  endtask

  // points near the set boundary, in thousandths
  function automatic int spot_milli(input int idx, input bit imag);
    case (idx)
      0: return imag ? 100  : -750;
      1: return imag ? 0    : -1250;
      2: return imag ? 10   : 280;
      3: return imag ? 650  : -100;
      4: return imag ? 0    : -1770;
      5: return imag ? 1000 : 0;
      6: return imag ? 0    : -2000;
      7: return imag ? 0    : 250;
      8: return imag ? 0    : -500;
      default: return imag ? 1030 : -160;
    endcase
  endfunction

  function automatic logic [DIM_W-1:0] view_size();
    int sel;
    sel = $urandom_range(0, 19);
    if (sel == 0) return '0;
    if (sel == 1) return DIM_W'($urandom_range(4097, 8191));
    if (sel <= 4) return DIM_W'($urandom_range(1, 4096));
    return DIM_W'($urandom_range(1, 48));
  endfunction

  function automatic logic signed [63:0] extreme_center();
    longint mag;
    case ($urandom_range(0, 4))
      0: return S64_TOP;
      1: return S64_BOTTOM;
      2: return '0;
      3: return {$urandom, $urandom};
      default: begin
        mag = longint'($urandom_range(3, 15)) <<< 59;
        return $urandom_range(0, 1) ? -mag : mag;
      end
    endcase
  endfunction

  function automatic logic [DIM_W-1:0] extreme_size();
    case ($urandom_range(0, 6))
      0: return 13'd0;
      1: return 13'd1;
      2: return 13'd2;
      3: return 13'd4096;
      4: return 13'd4097;
      5: return 13'd8191;
      default: return DIM_W'($urandom);
    endcase
  endfunction

  initial begin
    bit gaps;
    int sent, n, i, in_pct, idx, re_m, im_m, span_px, wx, hx;
    longint span;
    logic signed [63:0] cr, ci;
    logic [62:0] pitch;
    logic [DIM_W-1:0] w, h;
    logic [15:0] lim;
    logic [PIX_W-1:0] x, y;

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // register defaults straight out of reset: center, canvas corners, far outside
    send_pixel(12'd320, 12'd240, 1'b0);
    send_pixel(12'd0, 12'd0, 1'b0);
    send_pixel(12'd4095, 12'd4095, 1'b0);
    send_pixel(12'd4095, 12'd0, 1'b0);
    send_pixel(12'd0, 12'd4095, 1'b0);
    send_pixel(12'd639, 12'd479, 1'b0);
    send_pixel(12'd2048, 12'd2048, 1'b0);
    // zero pitch and zero canvas: c = 0 goes interior even with the widest limit
    load_registers('0, '0, '0, 13'd0, 13'd0, 16'hFFFF);
    send_pixel(12'd4095, 12'd4095, 1'b0);
    // saturated center escapes at the first iteration
    load_registers(S64_TOP, S64_TOP, '0, 13'd640, 13'd480, 16'hFFFF);
    send_pixel(12'd123, 12'd456, 1'b0);
    // clamped canvas, widest pitch, single iteration
    load_registers(S64_BOTTOM, S64_BOTTOM, PITCH_TOP, 13'd8191, 13'd4097, 16'd2);
    send_pixel(12'd0, 12'd0, 1'b0);
    send_pixel(12'd4095, 12'd4095, 1'b0);
    send_pixel(12'd2048, 12'd2048, 1'b0);
    // limits that allow no iteration at all
    load_registers('0, '0, MILLI_Q59[62:0], 13'd640, 13'd480, 16'd0);
    send_pixel(12'd0, 12'd0, 1'b0);
    load_registers('0, '0, MILLI_Q59[62:0], 13'd640, 13'd480, 16'd1);
    send_pixel(12'd0, 12'd0, 1'b0);
    send_pixel(12'd4095, 12'd4095, 1'b0);
    // c = -2 sits exactly on the radius and the derivative saturates
    load_registers(-TWO_Q59, '0, '0, 13'd1, 13'd1, 16'd40);
    send_pixel(12'd0, 12'd0, 1'b0);
    // odd canvas gives half-integer centers
    load_registers('0, '0, 63'(500 * MILLI_Q59), 13'd1, 13'd1, 16'd16);
    send_pixel(12'd0, 12'd0, 1'b0);
    send_pixel(12'd1, 12'd1, 1'b0);
    send_pixel(12'd2, 12'd0, 1'b0);
    load_registers(-750 * MILLI_Q59, 100 * MILLI_Q59, MILLI_Q59[62:0],
                   13'd4096, 13'd4096, 16'd30);
    send_pixel(12'd2048, 12'd2048, 1'b0);
    send_pixel(12'd0, 12'd4095, 1'b0);

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      gaps = (sent < QUIET_FROM) && ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 9) < 7) begin
        // a view onto the set: mostly pixels on the canvas
        idx = $urandom_range(0, 12);
        if (idx < 10) begin
          re_m = spot_milli(idx, 1'b0);
          im_m = spot_milli(idx, 1'b1);
        end else begin
          re_m = $urandom_range(0, 4000) - 2500;
          im_m = $urandom_range(0, 3000) - 1500;
        end
        cr = longint'(re_m) * MILLI_Q59 + longint'($urandom_range(0, 1 << 24));
        ci = longint'(im_m) * MILLI_Q59 + longint'($urandom_range(0, 1 << 24));
        w = view_size();
        h = view_size();
        span_px = (w == 0) ? 1 : ((w > 4096) ? 4096 : int'(w));
        span = $urandom_range(20, 4000);
        pitch = 63'((span * MILLI_Q59) / span_px);
        case ($urandom_range(0, 9))
          0: lim = 16'($urandom_range(0, 1));
          1: lim = 16'($urandom_range(24, 64));
          default: lim = 16'($urandom_range(2, 14));
        endcase
        n = (lim >= 24) ? $urandom_range(15, 25) : $urandom_range(40, 80);
        in_pct = 85;
      end else begin
        // extreme register values
        cr = extreme_center();
        ci = extreme_center();
        case ($urandom_range(0, 4))
          0: pitch = '0;
          1: pitch = 63'd1;
          2: pitch = PITCH_TOP;
          3: pitch = {$urandom, $urandom};
          default: pitch = 63'($urandom_range(0, 1 << 30));
        endcase
        w = extreme_size();
        h = extreme_size();
        lim = 16'($urandom_range(0, 12));
        if ($urandom_range(0, 5) == 0) begin
          // widest limit only where every point escapes at once
          lim = 16'hFFFF;
          pitch = 63'($urandom_range(0, 1 << 20));
          cr = $urandom_range(0, 1) ? S64_TOP : S64_BOTTOM;
        end
        n = $urandom_range(15, 30);
        in_pct = 50;
      end
      load_registers(cr, ci, pitch, w, h, lim);
      wx = (w == 0 || w > 4096) ? 4096 : int'(w);
      hx = (h == 0 || h > 4096) ? 4096 : int'(h);
      for (i = 0; i < n; i++) begin
        if ($urandom_range(0, 99) < in_pct) begin
          x = PIX_W'($urandom_range(0, wx - 1));
          y = PIX_W'($urandom_range(0, hx - 1));
        end else begin
          x = PIX_W'($urandom);
          y = PIX_W'($urandom);
        end
        send_pixel(x, y, gaps);
      end
      sent += n;
    end

    start <= 1'b0;
    while (sb.pending_q.size() != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);

    $display("checked %0d pixels under %0d register settings after the reset defaults",
             sb.pixels_noted, settings_used);
    $display("%0d pixels escaped, %0d were interior or ran to the limit",
             sb.escaped, sb.stayed);
    if (sb.mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
